/* rtl/cbor_ihe_pkg.sv */
// Shared types and constants for the CBOR item head encoder.
`default_nettype none
package cbor_ihe_pkg;

    localparam int OPCODE_W  = 4;
    localparam int VALUE_W   = 64;
    localparam int BYTE_W    = 8;
    localparam int IN_DATA_W = 64;   // value, already whole bytes
    localparam int NBYTES_W  = 4;    // argument byte count 0..8
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_UINT  = 4'd0,
        OP_SINT  = 4'd1,
        OP_BOOL  = 4'd2,
        OP_NULL  = 4'd3,
        OP_TEXT  = 4'd4,
        OP_BYTES = 4'd5,
        OP_ARRAY = 4'd6,
        OP_MAP   = 4'd7,
        OP_RAW   = 4'd8
    } t_opcode;

    localparam logic [BYTE_W-1:0] MT_UINT  = 8'h00;
    localparam logic [BYTE_W-1:0] MT_NINT  = 8'h20;
    localparam logic [BYTE_W-1:0] MT_BYTES = 8'h40;
    localparam logic [BYTE_W-1:0] MT_TEXT  = 8'h60;
    localparam logic [BYTE_W-1:0] MT_ARRAY = 8'h80;
    localparam logic [BYTE_W-1:0] MT_MAP   = 8'ha0;
    localparam logic [BYTE_W-1:0] SV_FALSE = 8'hf4;
    localparam logic [BYTE_W-1:0] SV_TRUE  = 8'hf5;
    localparam logic [BYTE_W-1:0] SV_NULL  = 8'hf6;

    localparam logic [BYTE_W-1:0] AI_MAX_DIRECT = 8'd23;
    localparam logic [BYTE_W-1:0] AI_1BYTE = 8'd24;
    localparam logic [BYTE_W-1:0] AI_2BYTE = 8'd25;
    localparam logic [BYTE_W-1:0] AI_4BYTE = 8'd26;
    localparam logic [BYTE_W-1:0] AI_8BYTE = 8'd27;

    // One classified command: head byte, argument and its byte count.
    typedef struct packed {
        logic [BYTE_W-1:0]   head;
        logic [VALUE_W-1:0]  arg;
        logic [NBYTES_W-1:0] nbytes;
    } t_cmd;

endpackage
`default_nettype wire

/* rtl/cbor_ihe_front.sv */
// Front end: decodes an input item into a head byte and argument bytes.
`default_nettype none
module cbor_ihe_front (
    input  wire logic [cbor_ihe_pkg::OPCODE_W-1:0] i_opcode,
    input  wire logic [cbor_ihe_pkg::VALUE_W-1:0]  i_value,
    output cbor_ihe_pkg::t_cmd                     o_cmd,
    output logic                                   o_known
);
    import cbor_ihe_pkg::*;

    logic [BYTE_W-1:0]  major;
    logic [VALUE_W-1:0] arg;
    logic               is_head;
    logic [BYTE_W-1:0]  simple;

    always_comb begin
        major   = MT_UINT;
        arg     = i_value;
        is_head = 1'b1;
        simple  = SV_NULL;
        o_known = 1'b1;
        unique case (i_opcode)
            OP_UINT:  major = MT_UINT;
            OP_SINT: begin
                if (i_value[VALUE_W-1]) begin
                    major = MT_NINT;
                    arg   = ~i_value;
                end
            end
            OP_BOOL: begin
                is_head = 1'b0;
                simple  = i_value[0] ? SV_TRUE : SV_FALSE;
            end
            OP_NULL: begin
                is_head = 1'b0;
                simple  = SV_NULL;
            end
            OP_TEXT:  major = MT_TEXT;
            OP_BYTES: major = MT_BYTES;
            OP_ARRAY: major = MT_ARRAY;
            OP_MAP:   major = MT_MAP;
            OP_RAW: begin
                is_head = 1'b0;
                simple  = i_value[BYTE_W-1:0];
            end
            default: begin
                is_head = 1'b0;
                o_known = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_cmd.arg = arg;
        if (!is_head) begin
            o_cmd.head   = simple;
            o_cmd.nbytes = NBYTES_W'(0);
        end else if (arg <= VALUE_W'(AI_MAX_DIRECT)) begin
            o_cmd.head   = major | arg[BYTE_W-1:0];
            o_cmd.nbytes = NBYTES_W'(0);
        end else if (arg[VALUE_W-1:8] == '0) begin
            o_cmd.head   = major | AI_1BYTE;
            o_cmd.nbytes = NBYTES_W'(1);
        end else if (arg[VALUE_W-1:16] == '0) begin
            o_cmd.head   = major | AI_2BYTE;
            o_cmd.nbytes = NBYTES_W'(2);
        end else if (arg[VALUE_W-1:32] == '0) begin
            o_cmd.head   = major | AI_4BYTE;
            o_cmd.nbytes = NBYTES_W'(4);
        end else begin
            o_cmd.head   = major | AI_8BYTE;
            o_cmd.nbytes = NBYTES_W'(8);
        end
    end

endmodule
`default_nettype wire

/* rtl/cbor_ihe_queue.sv */
// Short command queue between the front end and the byte serialiser.
`default_nettype none
module cbor_ihe_queue #(
    parameter int Depth = cbor_ihe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire cbor_ihe_pkg::t_cmd i_wr_cmd,
    input  wire logic               i_pop,
    output cbor_ihe_pkg::t_cmd      o_rd_cmd,
    output logic                    o_full,
    output logic                    o_empty
);
    import cbor_ihe_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_cmd            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    assign o_full   = (r_count == CntW'(Depth));
    assign o_empty  = (r_count == '0);
    assign o_rd_cmd = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CntW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Depth))
        else $error("queue count beyond depth");

endmodule
`default_nettype wire

/* rtl/cbor_ihe_back.sv */
// Back end: serialises one command into bytes through an output register.
`default_nettype none
module cbor_ihe_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire cbor_ihe_pkg::t_cmd              i_cmd,
    input  wire logic                            i_cmd_avail,
    output logic                                 o_cmd_pop,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [cbor_ihe_pkg::BYTE_W-1:0]      o_byte,
    output logic                                 o_last
);
    import cbor_ihe_pkg::*;

    logic                 r_busy, n_busy;
    logic [NBYTES_W-1:0]  r_rem, n_rem;
    logic [VALUE_W-1:0]   r_arg, n_arg;
    logic                 r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]    r_out_byte, n_out_byte;
    logic                 r_out_last, n_out_last;
    logic                 advance;
    logic [NBYTES_W-1:0]  rem_dec;
    logic [2:0]           sel;

    assign advance = !r_out_valid || i_ready;
    assign rem_dec = r_rem - NBYTES_W'(1);
    assign sel     = rem_dec[2:0];

    always_comb begin
        n_busy      = r_busy;
        n_rem       = r_rem;
        n_arg       = r_arg;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_cmd_pop   = 1'b0;
        if (advance) begin
            n_out_valid = 1'b0;
            if (r_busy) begin
                // emit argument bytes most significant first
                n_out_valid = 1'b1;
                n_out_byte  = r_arg[{sel, 3'b000} +: BYTE_W];
                n_out_last  = (r_rem == NBYTES_W'(1));
                n_rem       = rem_dec;
                n_busy      = (r_rem != NBYTES_W'(1));
            end else if (i_cmd_avail) begin
                o_cmd_pop   = 1'b1;
                n_out_valid = 1'b1;
                n_out_byte  = i_cmd.head;
                n_out_last  = (i_cmd.nbytes == '0);
                n_arg       = i_cmd.arg;
                n_rem       = i_cmd.nbytes;
                n_busy      = (i_cmd.nbytes != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_arg      <= n_arg;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem != '0 && r_rem <= NBYTES_W'(8)))
        else $error("argument byte count out of range while busy");
    a_last_matches_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == !r_busy))
        else $error("last marker disagrees with pending argument bytes");
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (!r_busy && advance))
        else $error("command popped while serialising");

endmodule
`default_nettype wire

/* rtl/cbor_item_head_encoder.sv */
// CBOR item head encoder: input stream of operations, output stream of bytes.
//
// Input channel (s_axis): one item per operation; tuser carries the opcode in
// bits [3:0] and tdata the 64-bit operand. Opcodes 9 to 15 are taken and
// dropped without output.
// Output channel (m_axis): one encoded byte per transfer in tdata, tlast high on
// the final byte of each input operation.
// Throughput: one output byte per cycle while the output is ready. An operation
// producing N bytes (1 to 9) occupies the serialiser until its last byte is loaded;
// single-byte operations stream at one per cycle while the output is ready.
// The first byte is written into the command queue at the accepting edge and is
// then loaded into the output register when the serialiser takes the command.
// The input side stalls only when the command queue is full, so up to
// QueueDepth decoded operations wait while the output side is stalled.
// A stalled output holds its byte and marker unchanged.
// Reset (synchronous, active low) empties the queue and the output register.
`default_nettype none
module cbor_item_head_encoder #(
    parameter int QueueDepth = cbor_ihe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // [63:0] value
    input  wire logic [cbor_ihe_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // [3:0] opcode
    input  wire logic [cbor_ihe_pkg::OPCODE_W-1:0]    i_s_axis_tuser,
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    // [7:0] out_byte
    output logic [cbor_ihe_pkg::BYTE_W-1:0]           o_m_axis_tdata,
    output logic                                      o_m_axis_tlast
);
    import cbor_ihe_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic known;
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;

    cbor_ihe_front u_front (
        .i_opcode (i_s_axis_tuser),
        .i_value  (i_s_axis_tdata[VALUE_W-1:0]),
        .o_cmd    (front_cmd),
        .o_known  (known)
    );

    assign o_s_axis_tready = !q_full;
    assign q_push          = i_s_axis_tvalid && !q_full && known;

    cbor_ihe_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_wr_cmd (front_cmd),
        .i_pop    (q_pop),
        .o_rd_cmd (queue_cmd),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    cbor_ihe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_avail (!q_empty),
        .o_cmd_pop   (q_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_byte      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

/* bench/cbor_item_head_encoder_tb.sv */
// Self-checking testbench for the CBOR item head encoder, with a byte-level predictor.
module cbor_item_head_encoder_tb;
    import cbor_ihe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS      = 410;
    localparam int RESET_CYCLES = 6;
    localparam int TAIL_CYCLES  = 12;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
    } t_op_item;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_enc_byte;

    typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // [63:0] value
    logic [IN_DATA_W-1:0] i_s_axis_tdata = '0;
    // [3:0] opcode
    logic [OPCODE_W-1:0]  i_s_axis_tuser = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // [7:0] out_byte
    logic [BYTE_W-1:0]    o_m_axis_tdata;
    logic                 o_m_axis_tlast;

    t_op_item  pending_ops[$];
    t_enc_byte expected_bytes[$];
    int        total_items = 0;
    int        accepted_cnt = 0;
    int        fail_cnt = 0;
    bit        in_taken = 1'b0;
    int        burst_left = 1;
    int        gap_left = 0;
    t_rx_mode  rx_mode = RX_FREE;
    int        rx_left = 0;

    cbor_item_head_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("cbor_item_head_encoder_tb failed");
        $finish;
    end

    function automatic void push_enc_byte(logic [BYTE_W-1:0] b, logic lst);
        t_enc_byte e;
        e.data = b;
        e.last = lst;
        expected_bytes.push_back(e);
    endfunction

    // Head byte, then the argument big-endian in the shortest form that holds it.
    function automatic void encode_head(logic [BYTE_W-1:0] major, logic [VALUE_W-1:0] arg);
        int                 nb;
        logic [BYTE_W-1:0]  info;
        logic [VALUE_W-1:0] shifted;
        if (arg <= 64'(AI_MAX_DIRECT)) begin
            push_enc_byte(major | arg[BYTE_W-1:0], 1'b1);
            return;
        end
        if (arg <= 64'hff) begin
            info = AI_1BYTE;
            nb = 1;
        end else if (arg <= 64'hffff) begin
            info = AI_2BYTE;
            nb = 2;
        end else if (arg <= 64'hffff_ffff) begin
            info = AI_4BYTE;
            nb = 4;
        end else begin
            info = AI_8BYTE;
            nb = 8;
        end
        push_enc_byte(major | info, 1'b0);
        for (int i = nb; i > 0; i--) begin
            shifted = arg >> (8 * (i - 1));
            push_enc_byte(shifted[BYTE_W-1:0], i == 1);
        end
    endfunction

    function automatic void predict_encoding(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] v);
        case (op)
            OP_UINT:  encode_head(MT_UINT, v);
            OP_SINT: begin
                // negative: major type 1 with argument -1 minus the value
                if (v[VALUE_W-1]) encode_head(MT_NINT, ~v);
                else encode_head(MT_UINT, v);
            end
            OP_BOOL:  push_enc_byte(v[0] ? SV_TRUE : SV_FALSE, 1'b1);
            OP_NULL:  push_enc_byte(SV_NULL, 1'b1);
            OP_TEXT:  encode_head(MT_TEXT, v);
            OP_BYTES: encode_head(MT_BYTES, v);
            OP_ARRAY: encode_head(MT_ARRAY, v);
            OP_MAP:   encode_head(MT_MAP, v);
            OP_RAW:   push_enc_byte(v[BYTE_W-1:0], 1'b1);
            default: ;
        endcase
    endfunction

    function automatic void queue_op(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] v);
        t_op_item it;
        it.opcode = op;
        it.value = v;
        pending_ops.push_back(it);
    endfunction

    // Argument spread over every head length, with the length boundaries favoured.
    function automatic logic [VALUE_W-1:0] random_arg();
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 23));
            1: return 64'($urandom_range(24, 255));
            2: return 64'($urandom_range(256, 65535));
            3: return {32'h0, $urandom} | 64'h1_0000;
            4: return {$urandom, $urandom};
            default: begin
                case ($urandom_range(0, 8))
                    0: return 64'd23;
                    1: return 64'd24;
                    2: return 64'hff;
                    3: return 64'h100;
                    4: return 64'hffff;
                    5: return 64'h1_0000;
                    6: return 64'hffff_ffff;
                    7: return 64'h1_0000_0000;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    // Sender: bursts of random length with random gaps between them.
    always @(negedge i_clk) begin : drive_ops
        t_op_item nxt;
        if (i_rst_n && (!i_s_axis_tvalid || in_taken)) begin
            if (gap_left != 0) begin
                i_s_axis_tvalid <= 1'b0;
                gap_left--;
            end else if (pending_ops.size() != 0) begin
                nxt = pending_ops.pop_front();
                i_s_axis_tdata  <= nxt.value;
                i_s_axis_tuser  <= nxt.opcode;
                i_s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern whose mode is chosen anew at random intervals.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:   i_m_axis_tready <= 1'b1;
            RX_RANDOM: i_m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
            default:   i_m_axis_tready <= ~i_m_axis_tready;
        endcase
    end

    // Check output bytes first, then record the item taken at this edge.
    always @(posedge i_clk) begin : watch_streams
        t_enc_byte want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual data=%02h last=%0b",
                         $time, o_m_axis_tdata, o_m_axis_tlast);
                fail_cnt++;
            end else begin
                want = expected_bytes.pop_front();
                if (o_m_axis_tdata !== want.data) begin
                    $display("%0t: byte mismatch: expected %02h, actual %02h",
                             $time, want.data, o_m_axis_tdata);
                    fail_cnt++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last, o_m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
        in_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (in_taken) begin
            predict_encoding(i_s_axis_tuser, i_s_axis_tdata[VALUE_W-1:0]);
            accepted_cnt++;
        end
    end

    initial begin : stimulus
        int                  len;
        logic [OPCODE_W-1:0] op;
        logic [VALUE_W-1:0]  v;

        // Head length boundaries, the sign cases, every other opcode and both ends of the unused range
        queue_op(OP_UINT, 64'd0);
        queue_op(OP_UINT, 64'd23);
        queue_op(OP_UINT, 64'd24);
        queue_op(OP_UINT, 64'hff);
        queue_op(OP_UINT, 64'h100);
        queue_op(OP_UINT, 64'hffff);
        queue_op(OP_UINT, 64'h1_0000);
        queue_op(OP_UINT, 64'hffff_ffff);
        queue_op(OP_UINT, 64'h1_0000_0000);
        queue_op(OP_UINT, '1);
        queue_op(OP_SINT, '1);
        queue_op(OP_SINT, -64'sd24);
        queue_op(OP_SINT, -64'sd257);
        queue_op(OP_SINT, 64'h8000_0000_0000_0000);
        queue_op(OP_SINT, 64'h7fff_ffff_ffff_ffff);
        queue_op(OP_BOOL, 64'hffff_ffff_ffff_fffe);
        queue_op(OP_BOOL, 64'd1);
        queue_op(OP_NULL, '1);
        queue_op(OP_TEXT, 64'd5);
        queue_op(OP_BYTES, 64'd300);
        queue_op(OP_ARRAY, 64'd70000);
        queue_op(OP_MAP, 64'h1_0000_0000);
        queue_op(OP_RAW, 64'hffff_ffff_ffff_ff00);
        queue_op(OP_UNUSED_LO, '1);
        queue_op(OP_UNUSED_HI, 64'd0);

        while (pending_ops.size() < N_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // string header followed by its payload bytes
                    len = $urandom_range(0, 12);
                    queue_op($urandom_range(0, 1) ? OP_TEXT : OP_BYTES, 64'(len));
                    repeat (len) begin
                        queue_op(OP_RAW, {$urandom, $urandom});
                    end
                end
                3: begin
                    // container header followed by its members
                    len = $urandom_range(0, 6);
                    queue_op($urandom_range(0, 1) ? OP_ARRAY : OP_MAP, 64'(len));
                    repeat (len) begin
                        queue_op($urandom_range(0, 1) ? OP_UINT : OP_SINT, random_arg());
                    end
                end
                4: begin
                    queue_op(OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                             {$urandom, $urandom});
                end
                default: begin
                    op = OPCODE_W'($urandom_range(OP_UINT, OP_RAW));
                    if (op == OP_SINT)
                        v = $urandom_range(0, 1) ? random_arg() : ~random_arg();
                    else if (op == OP_BOOL || op == OP_NULL || op == OP_RAW)
                        v = {$urandom, $urandom};
                    else
                        v = random_arg();
                    queue_op(op, v);
                end
            endcase
        end
        total_items = pending_ops.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt != total_items) @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("cbor_item_head_encoder_tb passed");
        else
            $display("cbor_item_head_encoder_tb failed");
        $finish;
    end

endmodule

/* cbor_item_head_encoder.f */
rtl/cbor_ihe_pkg.sv
rtl/cbor_ihe_front.sv
rtl/cbor_ihe_queue.sv
rtl/cbor_ihe_back.sv
rtl/cbor_item_head_encoder.sv
bench/cbor_item_head_encoder_tb.sv
